// ----- design/ckrt_pkg.sv -----
package ckrt_pkg;

   // Table geometry
   localparam int TABLE_DEPTH = 128;
   localparam int KEY_BYTES   = 7;
   localparam int GROUP_SIZE  = 8;
   localparam int NUM_GROUPS  = TABLE_DEPTH / GROUP_SIZE;

   // Field widths
   localparam int KEY_W     = 56;
   localparam int TIME_W    = 32;
   localparam int LEVEL_W   = 3;
   localparam int OP_W      = 2;
   localparam int STATUS_W  = 2;
   localparam int IDX_W     = $clog2(TABLE_DEPTH);
   localparam int CNT_W     = $clog2(TABLE_DEPTH + 1);
   localparam int GRP_IDX_W = $clog2(GROUP_SIZE);
   localparam int GRP_SEL_W = $clog2(NUM_GROUPS);

   // Only the low KEY_BYTES bytes of a plate take part
   localparam logic [KEY_W-1:0] KEY_MASK = (KEY_BYTES * 8 >= KEY_W) ? {KEY_W{1'b1}} :
      KEY_W'((64'd1 << (KEY_BYTES * 8)) - 64'd1);

   // Request codes
   localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_FIND   = 2'd2;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] ST_MISS = 2'd2;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [TIME_W-1:0]  entry_time;
      logic [TIME_W-1:0]  park_time;
      logic [LEVEL_W-1:0] level;
   } rec_type;

   // Broadcast from the sequencer to every cell
   typedef struct packed {
      logic             load_match;
      logic             do_add;
      logic             do_shift;
      logic [CNT_W-1:0] count;
      logic [IDX_W-1:0] pos;
      rec_type          rec;
   } cell_ctrl_type;

endpackage

// ----- design/ckrt_cell.sv -----
module ckrt_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [ckrt_pkg::IDX_W-1:0] cell_index,
   input  ckrt_pkg::cell_ctrl_type    ctrl,
   input  ckrt_pkg::rec_type          next_rec,
   output ckrt_pkg::rec_type          rec,
   output logic                       match
);
   import ckrt_pkg::*;

   rec_type rec_ff;
   rec_type rec_in;
   logic    match_ff;
   logic    match_in;
   logic    occupied;

   // Slot holds a live record when it sits below the fill count
   assign occupied = {1'b0, cell_index} < ctrl.count;

   // Local key compare, captured once per request
   always_comb begin
      match_in = match_ff;
      if (ctrl.load_match) begin
         match_in = occupied && (rec_ff.key == ctrl.rec.key);
      end
   end

   // Append at the fill point, or take the upper neighbor while compacting
   always_comb begin
      rec_in = rec_ff;
      if (ctrl.do_add && ({1'b0, cell_index} == ctrl.count)) begin
         rec_in = ctrl.rec;
      end else if (ctrl.do_shift && (cell_index >= ctrl.pos)) begin
         rec_in = next_rec;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   assign rec   = rec_ff;
   assign match = match_ff;

endmodule

// ----- design/ckrt_group.sv -----
module ckrt_group (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            load,
   input  logic [ckrt_pkg::GROUP_SIZE-1:0] match,
   input  ckrt_pkg::rec_type               recs [ckrt_pkg::GROUP_SIZE],
   output logic                            hit,
   output logic [ckrt_pkg::GRP_IDX_W-1:0]  index,
   output ckrt_pkg::rec_type               rec
);
   import ckrt_pkg::*;

   logic                 hit_ff;
   logic                 hit_in;
   logic [GRP_IDX_W-1:0] index_ff;
   logic [GRP_IDX_W-1:0] index_in;
   rec_type              rec_ff;
   rec_type              rec_in;

   // First matching slot in this group; scan from the top so the lowest wins
   always_comb begin
      hit_in   = 1'b0;
      index_in = '0;
      rec_in   = '0;
      for (int j = GROUP_SIZE - 1; j >= 0; j--) begin
         if (match[j]) begin
            hit_in   = 1'b1;
            index_in = GRP_IDX_W'(j);
            rec_in   = recs[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else if (load) begin
         hit_ff <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         index_ff <= index_in;
         rec_ff   <= rec_in;
      end
   end

   assign hit   = hit_ff;
   assign index = index_ff;
   assign rec   = rec_ff;

endmodule

// ----- design/compacting_keyed_record_table_core.sv -----
// Channel   Direction  Transfer                     Payload
// request   in         start & !busy at clock edge  req_type, req_key_plate, req_entry_time,
//                                                   req_park_time, req_park_level
// response  out        rsp_strobe, one cycle        rsp_status, rsp_match_index,
//                                                   rsp_entry_count, rsp_found_*
//
// Each request passes from accept to the response strobe through the compare in every
// cell, the per-group first-match select, the final group select with the table update,
// and the response register, in that order.
// busy falls in the cycle the response is shown, so a new request can be taken then.
// Reset clears the fill count and the sequencer; record contents are not cleared.
// The receiver cannot stall: every response is shown for exactly one cycle.
module compacting_keyed_record_table_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [ckrt_pkg::OP_W-1:0]      req_type,
   input  logic [ckrt_pkg::KEY_W-1:0]     req_key_plate,
   input  logic [ckrt_pkg::TIME_W-1:0]    req_entry_time,
   input  logic [ckrt_pkg::TIME_W-1:0]    req_park_time,
   input  logic [ckrt_pkg::LEVEL_W-1:0]   req_park_level,
   output logic                           rsp_strobe,
   output logic [ckrt_pkg::STATUS_W-1:0]  rsp_status,
   output logic [ckrt_pkg::IDX_W-1:0]     rsp_match_index,
   output logic [ckrt_pkg::CNT_W-1:0]     rsp_entry_count,
   output logic [ckrt_pkg::TIME_W-1:0]    rsp_found_entry_time,
   output logic [ckrt_pkg::TIME_W-1:0]    rsp_found_park_time,
   output logic [ckrt_pkg::LEVEL_W-1:0]   rsp_found_level
);
   import ckrt_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_CMP  = 2'd1;
   localparam logic [1:0] S_GRP  = 2'd2;
   localparam logic [1:0] S_FIN  = 2'd3;

   logic [1:0]       state_ff;
   logic [1:0]       state_in;
   logic [OP_W-1:0]  op_ff;
   rec_type          req_rec_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             accept;

   cell_ctrl_type    ctrl;
   rec_type          cell_rec [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] cell_match;

   logic                 grp_hit [NUM_GROUPS];
   logic [GRP_IDX_W-1:0] grp_index [NUM_GROUPS];
   rec_type              grp_rec [NUM_GROUPS];

   logic                 hit;
   logic [GRP_SEL_W-1:0] sel;
   logic [IDX_W-1:0]     pos;
   rec_type              found_rec;
   logic                 full;
   logic                 fin;

   logic                rsp_strobe_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [STATUS_W-1:0] rsp_status_in;
   logic [IDX_W-1:0]    rsp_index_ff;
   logic [IDX_W-1:0]    rsp_index_in;
   logic [CNT_W-1:0]    rsp_count_ff;
   rec_type             rsp_rec_ff;
   rec_type             rsp_rec_in;

   assign busy   = state_ff != S_IDLE;
   assign accept = start && !busy;
   assign fin    = state_ff == S_FIN;
   assign full   = count_ff >= CNT_W'(TABLE_DEPTH);

   // Sequencer
   always_comb begin
      unique case (state_ff)
         S_IDLE:  state_in = accept ? S_CMP : S_IDLE;
         S_CMP:   state_in = S_GRP;
         S_GRP:   state_in = S_FIN;
         S_FIN:   state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // Request capture; key is masked once here so stored keys are masked too
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff                 <= req_type;
         req_rec_ff.key        <= req_key_plate & KEY_MASK;
         req_rec_ff.entry_time <= req_entry_time;
         req_rec_ff.park_time  <= req_park_time;
         req_rec_ff.level      <= req_park_level;
      end
   end

   // Broadcast to the row of cells
   always_comb begin
      ctrl.load_match = state_ff == S_CMP;
      ctrl.do_add     = fin && (op_ff == OP_ADD) && !full;
      ctrl.do_shift   = fin && (op_ff == OP_REMOVE) && hit;
      ctrl.count      = count_ff;
      ctrl.pos        = pos;
      ctrl.rec        = req_rec_ff;
   end

   // Row of cells, each fed by its upper neighbor
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      rec_type upper;
      if (i == TABLE_DEPTH - 1) begin : g_top
         assign upper = '0;
      end else begin : g_mid
         assign upper = cell_rec[i + 1];
      end
      ckrt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (IDX_W'(i)),
         .ctrl       (ctrl),
         .next_rec   (upper),
         .rec        (cell_rec[i]),
         .match      (cell_match[i])
      );
   end

   // First-match select, level one
   for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_group
      rec_type grp_in [GROUP_SIZE];
      for (genvar j = 0; j < GROUP_SIZE; j++) begin : g_tap
         assign grp_in[j] = cell_rec[g * GROUP_SIZE + j];
      end
      ckrt_group u_group (
         .clock (clock),
         .reset (reset),
         .load  (state_ff == S_GRP),
         .match (cell_match[g * GROUP_SIZE +: GROUP_SIZE]),
         .recs  (grp_in),
         .hit   (grp_hit[g]),
         .index (grp_index[g]),
         .rec   (grp_rec[g])
      );
   end

   // First-match select, level two
   always_comb begin
      hit = 1'b0;
      sel = '0;
      for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
         if (grp_hit[g]) begin
            hit = 1'b1;
            sel = GRP_SEL_W'(g);
         end
      end
   end

   assign pos       = {sel, grp_index[sel]};
   assign found_rec = grp_rec[sel];

   // Fill count and response contents
   always_comb begin
      count_in      = count_ff;
      rsp_status_in = ST_DONE;
      rsp_index_in  = '0;
      rsp_rec_in    = '0;
      if (fin) begin
         unique case (op_ff)
            OP_ADD: begin
               if (full) begin
                  rsp_status_in = ST_FULL;
               end else begin
                  count_in = count_ff + CNT_W'(1);
               end
            end
            OP_REMOVE: begin
               if (hit) begin
                  rsp_index_in = pos;
                  count_in     = count_ff - CNT_W'(1);
               end else begin
                  rsp_status_in = ST_MISS;
               end
            end
            OP_FIND: begin
               if (hit) begin
                  rsp_index_in = pos;
                  rsp_rec_in   = found_rec;
               end else begin
                  rsp_status_in = ST_MISS;
               end
            end
            default: begin
               rsp_status_in = ST_DONE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= fin;
      end
   end

   always_ff @(posedge clock) begin
      if (fin) begin
         rsp_status_ff <= rsp_status_in;
         rsp_index_ff  <= rsp_index_in;
         rsp_count_ff  <= count_in;
         rsp_rec_ff    <= rsp_rec_in;
      end
   end

   assign rsp_strobe           = rsp_strobe_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_match_index      = rsp_index_ff;
   assign rsp_entry_count      = rsp_count_ff;
   assign rsp_found_entry_time = rsp_rec_ff.entry_time;
   assign rsp_found_park_time  = rsp_rec_ff.park_time;
   assign rsp_found_level      = rsp_rec_ff.level;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("fill count beyond table depth");

   a_rsp_after_fin: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff) == S_FIN)
      else $error("response without a finishing step");

   a_rsp_count: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_entry_count == count_ff)
      else $error("reported count differs from fill count");

   a_remove_shrinks: assert property (@(posedge clock) disable iff (reset)
      (fin && (op_ff == OP_REMOVE) && hit) |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("remove did not shrink the table");

   a_one_request: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |=> $stable(op_ff))
      else $error("request changed while in progress");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
   import ckrt_pkg::*;

   // Request code with no operation behind it
   localparam logic [OP_W-1:0] OP_NONE = 2'd3;

   localparam int RANDOM_ITEMS = 600;
   localparam int PHASE_ITEMS  = 150;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 200000;

   // One expected response
   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [IDX_W-1:0]    index;
      logic [CNT_W-1:0]    count;
      logic [TIME_W-1:0]   entry_time;
      logic [TIME_W-1:0]   park_time;
      logic [LEVEL_W-1:0]  level;
   } reply_type;

   logic                clock;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [OP_W-1:0]     req_type = OP_NONE;
   logic [KEY_W-1:0]    req_key_plate = '0;
   logic [TIME_W-1:0]   req_entry_time = '0;
   logic [TIME_W-1:0]   req_park_time = '0;
   logic [LEVEL_W-1:0]  req_park_level = '0;
   logic                rsp_strobe;
   logic [STATUS_W-1:0] rsp_status;
   logic [IDX_W-1:0]    rsp_match_index;
   logic [CNT_W-1:0]    rsp_entry_count;
   logic [TIME_W-1:0]   rsp_found_entry_time;
   logic [TIME_W-1:0]   rsp_found_park_time;
   logic [LEVEL_W-1:0]  rsp_found_level;

   // Shadow copy of the record table
   logic [KEY_W-1:0]    plate_table [TABLE_DEPTH];
   logic [TIME_W-1:0]   entry_table [TABLE_DEPTH];
   logic [TIME_W-1:0]   park_table [TABLE_DEPTH];
   logic [LEVEL_W-1:0]  level_table [TABLE_DEPTH];
   int                  record_count = 0;

   reply_type           reply_q [$];
   int                  mismatch_count = 0;
   int                  cycle_count = 0;
   bit                  idle_on = 1'b1;

   compacting_keyed_record_table_core dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_type             (req_type),
      .req_key_plate        (req_key_plate),
      .req_entry_time       (req_entry_time),
      .req_park_time        (req_park_time),
      .req_park_level       (req_park_level),
      .rsp_strobe           (rsp_strobe),
      .rsp_status           (rsp_status),
      .rsp_match_index      (rsp_match_index),
      .rsp_entry_count      (rsp_entry_count),
      .rsp_found_entry_time (rsp_found_entry_time),
      .rsp_found_park_time  (rsp_found_park_time),
      .rsp_found_level      (rsp_found_level)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout at %0t ns with %0d responses outstanding", $time, reply_q.size());
         $display("Mismatches found");
         $finish;
      end
   end

   // First valid record holding the plate, -1 when none
   function automatic int first_plate_match(logic [KEY_W-1:0] plate);
      for (int i = 0; i < record_count; i++) begin
         if (plate_table[i] == plate) return i;
      end
      return -1;
   endfunction

   // Apply one request to the shadow table and queue the response it gives
   function automatic void predict_table_reply(logic [OP_W-1:0] op, logic [KEY_W-1:0] plate,
                                               logic [TIME_W-1:0] et, logic [TIME_W-1:0] pt,
                                               logic [LEVEL_W-1:0] lvl);
      reply_type r;
      int     pos;
      logic [KEY_W-1:0] k;
      k = plate & KEY_MASK;
      r = '{default: '0};
      case (op)
         OP_ADD: begin
            if (record_count >= TABLE_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               plate_table[record_count] = k;
               entry_table[record_count] = et;
               park_table[record_count]  = pt;
               level_table[record_count] = lvl;
               record_count++;
            end
         end
         OP_REMOVE: begin
            pos = first_plate_match(k);
            if (pos < 0) begin
               r.status = ST_MISS;
            end else begin
               r.index = IDX_W'(pos);
               // compact: later records move down one place
               for (int i = pos; i < record_count - 1; i++) begin
                  plate_table[i] = plate_table[i+1];
                  entry_table[i] = entry_table[i+1];
                  park_table[i]  = park_table[i+1];
                  level_table[i] = level_table[i+1];
               end
               record_count--;
            end
         end
         OP_FIND: begin
            pos = first_plate_match(k);
            if (pos < 0) begin
               r.status = ST_MISS;
            end else begin
               r.index      = IDX_W'(pos);
               r.entry_time = entry_table[pos];
               r.park_time  = park_table[pos];
               r.level      = level_table[pos];
            end
         end
         default: ;
      endcase
      r.count = CNT_W'(record_count);
      reply_q.push_back(r);
   endfunction

   function automatic logic [KEY_W-1:0] random_plate();
      logic [63:0] w;
      w = {$urandom(), $urandom()};
      return w[KEY_W-1:0];
   endfunction

   // Plate of a random valid record; caller makes sure the table is not empty
   function automatic logic [KEY_W-1:0] stored_plate();
      return plate_table[$urandom_range(0, record_count - 1)];
   endfunction

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   // Send one request; returns at the edge that completes the transfer, start still high
   task automatic send_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] plate,
                               logic [TIME_W-1:0] et, logic [TIME_W-1:0] pt,
                               logic [LEVEL_W-1:0] lvl);
      int gap;
      gap = idle_on ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_type       <= op;
      req_key_plate  <= plate;
      req_entry_time <= et;
      req_park_time  <= pt;
      req_park_level <= lvl;
      // sample busy mid-cycle, where it is stable for the next edge
      do @(negedge clock); while (busy);
      predict_table_reply(op, plate, et, pt, lvl);
      @(posedge clock);
   endtask

   // Stop sending until every queued response has come back
   task automatic wait_for_replies();
      start <= 1'b0;
      while (reply_q.size() != 0) @(posedge clock);
   endtask

   // Response checker, sampled mid-cycle
   always @(negedge clock) begin
      reply_type want;
      if (!reset && rsp_strobe) begin
         if (reply_q.size() == 0) begin
            $display("%0t ns: response with none expected, status %0h index %0h count %0h",
                     $time, rsp_status, rsp_match_index, rsp_entry_count);
            mismatch_count++;
         end else begin
            want = reply_q.pop_front();
            check_field("status", 64'(want.status), 64'(rsp_status));
            check_field("match_index", 64'(want.index), 64'(rsp_match_index));
            check_field("entry_count", 64'(want.count), 64'(rsp_entry_count));
            check_field("found_entry_time", 64'(want.entry_time), 64'(rsp_found_entry_time));
            check_field("found_park_time", 64'(want.park_time), 64'(rsp_found_park_time));
            check_field("found_level", 64'(want.level), 64'(rsp_found_level));
         end
      end
   end

   // Empty table, field extremes, duplicates, removal with compaction, unused code
   task automatic test_basic_ops();
      logic [KEY_W-1:0] plate_a;
      logic [KEY_W-1:0] plate_b;
      plate_a = {7{8'hAA}};
      plate_b = {7{8'h55}};
      idle_on = 1'b1;
      send_request(OP_FIND, plate_a, '0, '0, '0);
      send_request(OP_REMOVE, plate_a, '0, '0, '0);
      send_request(OP_ADD, '1, '1, '0, 3'd7);
      send_request(OP_ADD, '0, '0, '1, 3'd0);
      send_request(OP_ADD, plate_a, $urandom(), $urandom(), 3'd5);
      send_request(OP_ADD, plate_a, $urandom(), $urandom(), 3'd1);
      send_request(OP_ADD, plate_b, 32'hAAAA_5555, 32'h5555_AAAA, 3'd3);
      send_request(OP_FIND, '1, '0, '0, '0);
      send_request(OP_FIND, '0, '1, '1, '1);
      send_request(OP_FIND, plate_a, '0, '0, '0);
      send_request(OP_FIND, plate_b, '0, '0, '0);
      send_request(OP_FIND, random_plate(), '0, '0, '0);
      send_request(OP_NONE, '1, '1, '1, '1);
      send_request(OP_REMOVE, plate_a, '1, '1, '1);
      send_request(OP_FIND, plate_a, '0, '0, '0);
      send_request(OP_FIND, plate_b, '0, '0, '0);
      send_request(OP_REMOVE, random_plate(), '0, '0, '0);
      send_request(OP_REMOVE, '1, '0, '0, '0);
      send_request(OP_REMOVE, plate_b, '0, '0, '0);
      send_request(OP_FIND, '0, '0, '0, '0);
      wait_for_replies();
   endtask

   // Fill to capacity, add when full, remove at both ends of a full table
   task automatic test_full_table();
      idle_on = 1'b0;
      while (record_count < TABLE_DEPTH) begin
         send_request(OP_ADD, random_plate(), $urandom(), $urandom(), 3'($urandom_range(0, 7)));
      end
      idle_on = 1'b1;
      send_request(OP_ADD, '1, '1, '1, 3'd7);
      send_request(OP_ADD, random_plate(), '0, '0, 3'd0);
      send_request(OP_FIND, plate_table[TABLE_DEPTH-1], '0, '0, '0);
      send_request(OP_REMOVE, plate_table[TABLE_DEPTH-1], '0, '0, '0);
      send_request(OP_ADD, random_plate(), $urandom(), $urandom(), 3'd4);
      send_request(OP_REMOVE, plate_table[0], '0, '0, '0);
      send_request(OP_FIND, plate_table[TABLE_DEPTH-2], '0, '0, '0);
      wait_for_replies();
   endtask

   // Phases that drain, grow and mix the table; most keys hit stored records
   task automatic test_random_traffic();
      int               pick;
      int               add_pct;
      int               remove_pct;
      logic [OP_W-1:0]  op;
      logic [KEY_W-1:0] plate;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 40 == 0) idle_on = ($urandom_range(0, 3) != 0);
         if (n % 100 == 99) wait_for_replies();
         case ((n / PHASE_ITEMS) % 3)
            0: begin
               add_pct = 5;
               remove_pct = 65;
            end
            1: begin
               add_pct = 60;
               remove_pct = 10;
            end
            default: begin
               add_pct = 35;
               remove_pct = 30;
            end
         endcase
         pick = $urandom_range(0, 99);
         if (pick < add_pct) op = OP_ADD;
         else if (pick < add_pct + remove_pct) op = OP_REMOVE;
         else if (pick < 95) op = OP_FIND;
         else op = OP_NONE;
         // duplicates on some adds, mostly hits on remove and find
         if (op == OP_ADD)
            plate = (record_count > 0 && $urandom_range(0, 3) == 0) ? stored_plate()
                                                                     : random_plate();
         else
            plate = (record_count > 0 && $urandom_range(0, 99) < 85) ? stored_plate()
                                                                      : random_plate();
         send_request(op, plate, $urandom(), $urandom(), 3'($urandom_range(0, 7)));
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_basic_ops();
      test_full_table();
      test_random_traffic();
      wait_for_replies();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ----- files.f -----
design/ckrt_pkg.sv
design/ckrt_cell.sv
design/ckrt_group.sv
design/compacting_keyed_record_table_core.sv
tb/tb_top.sv
